FILE: rtl/nmv_pkg.sv
`timescale 1ns / 1ps

package nmv_pkg;

    // Record header flag bit positions
    localparam int unsigned MB_POS = 7;
    localparam int unsigned ME_POS = 6;
    localparam int unsigned CF_POS = 5;
    localparam int unsigned SR_POS = 4;
    localparam int unsigned IL_POS = 3;

    // Type name format codes
    localparam logic [2:0] TNF_EMPTY     = 3'd0;
    localparam logic [2:0] TNF_UNKNOWN   = 3'd5;
    localparam logic [2:0] TNF_UNCHANGED = 3'd6;

    // Shortest legal message, in bytes
    localparam logic [1:0] MIN_MSG_BYTES = 2'd3;

    // Last index of a four-byte payload length
    localparam logic [1:0] LEN_IDX_LAST = 2'd3;

    // Result status codes
    localparam logic [3:0] ST_OK               = 4'd0;
    localparam logic [3:0] ST_TOO_SHORT        = 4'd1;
    localparam logic [3:0] ST_NO_BEGIN         = 4'd2;
    localparam logic [3:0] ST_UNEXPECTED_CHUNK = 4'd3;
    localparam logic [3:0] ST_EXTRA_BEGIN      = 4'd4;
    localparam logic [3:0] ST_BAD_CHUNK        = 4'd5;
    localparam logic [3:0] ST_BAD_EMPTY        = 4'd6;
    localparam logic [3:0] ST_LENGTH_MISMATCH  = 4'd7;
    localparam logic [3:0] ST_NO_END           = 4'd8;

    // Parse phases
    typedef enum logic [5:0] {
        PH_HDR       = 6'b000001,
        PH_TYPELEN   = 6'b000010,
        PH_PLEN      = 6'b000100,
        PH_IDLEN     = 6'b001000,
        PH_SKIP      = 6'b010000,
        PH_AFTER_END = 6'b100000
    } t_phase;

    // One byte handed from the input stage to the parser
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } t_step_req;

endpackage

FILE: rtl/nmv_parser.sv
`timescale 1ns / 1ps

module nmv_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nmv_pkg::t_step_req i_req,
    input  logic               i_allow_chunks,
    output logic [3:0]         o_status
);
    import nmv_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_tname_len, n_tname_len;
    logic [7:0]  r_id_len, n_id_len;
    logic [31:0] r_pay_len, n_pay_len;
    logic [1:0]  r_len_idx, n_len_idx;
    logic [33:0] r_skip, n_skip;
    logic        r_inside, n_inside;
    logic        r_first_done, n_first_done;
    logic [1:0]  r_bytes_seen, n_bytes_seen;
    logic [3:0]  r_pending, n_pending;

    // Header completion inputs and results
    logic [31:0] hd_pay_len;
    logic [31:0] shifted_len;
    logic [7:0]  hd_id_len;
    logic [2:0]  tnf;
    logic        has_fields;
    logic [33:0] hd_sum;
    logic [3:0]  hd_err;
    logic        hd_inside;
    t_phase      hd_phase;
    logic [33:0] hd_skip;
    logic [33:0] skip_dec;
    logic [3:0]  final_status;

    // Close out a header: chunk rules, empty and unknown checks, body length
    always_comb begin
        shifted_len = {r_pay_len[23:0], i_req.data};
        hd_pay_len  = (r_phase == PH_IDLEN) ? r_pay_len : shifted_len;
        hd_id_len   = (r_phase == PH_IDLEN) ? i_req.data : r_id_len;
        tnf         = r_flags[2:0];
        has_fields  = (r_tname_len != 8'd0) || (hd_id_len != 8'd0);
        hd_sum      = {2'b00, hd_pay_len} + {26'd0, r_tname_len} + {26'd0, hd_id_len};
        hd_err      = ST_OK;
        hd_inside   = r_inside;
        hd_phase    = r_phase;
        hd_skip     = r_skip;
        if (r_flags[CF_POS]) begin
            if (!i_allow_chunks) begin
                hd_err = ST_UNEXPECTED_CHUNK;
            end else if (r_inside) begin
                if (has_fields || tnf != TNF_UNCHANGED) hd_err = ST_BAD_CHUNK;
            end else if (tnf == TNF_UNCHANGED) begin
                hd_err = ST_BAD_CHUNK;
            end else begin
                hd_inside = 1'b1;
            end
        end else begin
            if (r_inside) begin
                if (has_fields || tnf != TNF_UNCHANGED) hd_err = ST_BAD_CHUNK;
                else hd_inside = 1'b0;
            end else if (tnf == TNF_UNCHANGED) begin
                hd_err = ST_BAD_CHUNK;
            end
        end
        if (hd_err == ST_OK) begin
            if (tnf == TNF_EMPTY && (has_fields || hd_pay_len != 32'd0)) begin
                hd_err = ST_BAD_EMPTY;
            end else if (tnf == TNF_UNKNOWN && r_tname_len != 8'd0) begin
                hd_err = ST_LENGTH_MISMATCH;
            end else begin
                hd_skip = hd_sum;
                if (hd_sum == 34'd0) hd_phase = r_flags[ME_POS] ? PH_AFTER_END : PH_HDR;
                else hd_phase = PH_SKIP;
            end
        end
    end

    // Advance the parse state by one byte
    always_comb begin
        n_phase      = r_phase;
        n_flags      = r_flags;
        n_tname_len  = r_tname_len;
        n_id_len     = r_id_len;
        n_pay_len    = r_pay_len;
        n_len_idx    = r_len_idx;
        n_skip       = r_skip;
        n_inside     = r_inside;
        n_first_done = r_first_done;
        n_bytes_seen = r_bytes_seen;
        n_pending    = r_pending;
        skip_dec     = (r_skip != 34'd0) ? (r_skip - 34'd1) : r_skip;

        if (r_bytes_seen < MIN_MSG_BYTES) n_bytes_seen = r_bytes_seen + 2'd1;

        if (r_pending == ST_OK) begin
            case (r_phase)
                PH_HDR: begin
                    n_flags     = i_req.data;
                    n_tname_len = 8'd0;
                    n_id_len    = 8'd0;
                    n_pay_len   = 32'd0;
                    n_len_idx   = 2'd0;
                    n_phase     = PH_TYPELEN;
                end
                PH_TYPELEN: begin
                    n_tname_len = i_req.data;
                    n_phase     = PH_PLEN;
                end
                PH_PLEN: begin
                    if (r_len_idx == 2'd0 && !r_first_done && !r_flags[MB_POS]) begin
                        n_pending = ST_NO_BEGIN;
                    end else if (r_len_idx == 2'd0 && !r_first_done
                                 && r_flags[2:0] == TNF_UNCHANGED) begin
                        n_pending = ST_UNEXPECTED_CHUNK;
                    end else if (r_len_idx == 2'd0 && r_first_done && r_flags[MB_POS]) begin
                        n_pending = ST_EXTRA_BEGIN;
                    end else begin
                        n_pay_len = shifted_len;
                        if (r_flags[SR_POS] || r_len_idx == LEN_IDX_LAST) begin
                            if (r_flags[IL_POS]) begin
                                n_phase = PH_IDLEN;
                            end else begin
                                n_first_done = 1'b1;
                                n_pending    = hd_err;
                                n_inside     = hd_inside;
                                n_phase      = hd_phase;
                                n_skip       = hd_skip;
                            end
                        end else begin
                            n_len_idx = r_len_idx + 2'd1;
                        end
                    end
                end
                PH_IDLEN: begin
                    n_id_len     = i_req.data;
                    n_first_done = 1'b1;
                    n_pending    = hd_err;
                    n_inside     = hd_inside;
                    n_phase      = hd_phase;
                    n_skip       = hd_skip;
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 34'd0) n_phase = r_flags[ME_POS] ? PH_AFTER_END : PH_HDR;
                end
                default: begin
                    n_pending = ST_LENGTH_MISMATCH;
                end
            endcase
        end

        // Status of the message as it stands after this byte
        if (n_pending != ST_OK) begin
            final_status = n_pending;
        end else begin
            case (n_phase)
                PH_HDR:       final_status = ST_NO_END;
                PH_SKIP:      final_status = n_flags[ME_POS] ? ST_LENGTH_MISMATCH : ST_NO_END;
                PH_AFTER_END: final_status = (n_bytes_seen < MIN_MSG_BYTES) ? ST_TOO_SHORT
                                                                            : ST_OK;
                default:      final_status = ST_TOO_SHORT;
            endcase
        end
    end

    assign o_status = final_status;

    // Hold parse state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_req.valid && i_req.last)) begin
            r_phase      <= PH_HDR;
            r_flags      <= 8'd0;
            r_tname_len  <= 8'd0;
            r_id_len     <= 8'd0;
            r_pay_len    <= 32'd0;
            r_len_idx    <= 2'd0;
            r_skip       <= 34'd0;
            r_inside     <= 1'b0;
            r_first_done <= 1'b0;
            r_bytes_seen <= 2'd0;
            r_pending    <= ST_OK;
        end else if (i_req.valid) begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_tname_len  <= n_tname_len;
            r_id_len     <= n_id_len;
            r_pay_len    <= n_pay_len;
            r_len_idx    <= n_len_idx;
            r_skip       <= n_skip;
            r_inside     <= n_inside;
            r_first_done <= n_first_done;
            r_bytes_seen <= n_bytes_seen;
            r_pending    <= n_pending;
        end
    end

endmodule

FILE: rtl/ndef_message_validator.sv
`timescale 1ns / 1ps

// NDEF message validator. Feed the message one byte per request, with
// i_last_byte set on the final byte; exactly one status comes out for each
// message, loaded as its final byte leaves the input register, and no request
// is answered for the other bytes. The block takes one byte every cycle unless
// stalled: each byte passes an input register, one header or body-skip step of
// the parser, and for the final byte the result register. Input is stalled
// only while a final byte waits behind a status that has not been taken. Write
// i_allow_chunks only while no message is in flight; it survives messages.
module ndef_message_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_msg_byte,
    input  logic       i_last_byte,
    input  logic       i_allow_chunks_we,
    input  logic       i_allow_chunks,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_status
);
    import nmv_pkg::*;

    logic       r_allow_chunks;
    logic       r_in_valid;
    logic       r_in_last;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [3:0] r_out_status;
    logic       out_free;
    logic       advance;
    logic [3:0] step_status;
    t_step_req  step_req;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && !advance;

    assign step_req.valid = advance;
    assign step_req.last  = r_in_last;
    assign step_req.data  = r_in_byte;

    // Hold the configuration bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_chunks <= 1'b0;
        end else if (i_allow_chunks_we) begin
            r_allow_chunks <= i_allow_chunks;
        end
    end

    // Capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_msg_byte;
            r_in_last <= i_last_byte;
        end
    end

    nmv_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (step_req),
        .i_allow_chunks (r_allow_chunks),
        .o_status       (step_status)
    );

    // Load the status on the final byte; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_status <= step_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;

endmodule

FILE: rtl/nmv_checker.sv
`timescale 1ns / 1ps

module nmv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_status
);
    import nmv_pkg::*;

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("result or stall present after reset");

    // With no result pending, input is never stalled
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the result register is empty");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_NO_END))
        else $error("status code out of range");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind ndef_message_validator nmv_checker u_nmv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_status (o_status)
);
